// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition on every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// check that an antecedent implies a consequence in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/arp_pkg.sv =====
`timescale 1ns / 1ps
package arp_pkg;

    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int TTL_W  = 16;
    localparam int RTR_W  = 8;
    localparam int TICK_W = 32;
    localparam int IDX_W  = 3;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_ARP   = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    localparam logic [IDX_W-1:0] CFG_LOCAL_IP     = 3'd0;
    localparam logic [IDX_W-1:0] CFG_OK_TTL       = 3'd1;
    localparam logic [IDX_W-1:0] CFG_PENDING_TTL  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_MAX_RETRIES  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_TIMER_PERIOD = 3'd4;

    localparam logic [15:0] ARP_HW_ETHERNET = 16'h0001;
    localparam logic [15:0] ARP_PROTO_IPV4  = 16'h0800;
    localparam logic [7:0]  ARP_HW_LEN      = 8'd6;
    localparam logic [7:0]  ARP_PROTO_LEN   = 8'd4;
    localparam logic [15:0] ARP_OP_REQUEST  = 16'd1;
    localparam logic [15:0] ARP_OP_REPLY    = 16'd2;

    localparam logic [TTL_W-1:0]  RST_OK_TTL       = 16'd5;
    localparam logic [TTL_W-1:0]  RST_PENDING_TTL  = 16'd1;
    localparam logic [RTR_W-1:0]  RST_MAX_RETRIES  = 8'd3;
    localparam logic [TICK_W-1:0] RST_TIMER_PERIOD = 32'd1;

    typedef enum logic [2:0] {
        K_NONE,
        K_AGE,
        K_ARP_REQ,
        K_ARP_REP,
        K_QUERY
    } t_kind;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_REQUEST = 2'd1,
        ACT_REPLY   = 2'd2,
        ACT_HIT     = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_OK      = 2'd1,
        ST_PENDING = 2'd2
    } t_entry_state;

    typedef struct packed {
        t_kind              kind;
        logic [IP_W-1:0]    ip;
        logic [MAC_W-1:0]   mac;
    } t_cmd;

    typedef struct packed {
        logic [TTL_W-1:0] ok_ttl;
        logic [TTL_W-1:0] pending_ttl;
        logic [RTR_W-1:0] max_retries;
    } t_age_cfg;

endpackage

// ===== rtl/arp_front.sv =====
`timescale 1ns / 1ps
module arp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_func,
    input  logic [15:0]                   i_hw_type,
    input  logic [15:0]                   i_proto_type,
    input  logic [7:0]                    i_hw_len,
    input  logic [7:0]                    i_proto_len,
    input  logic [15:0]                   i_arp_op,
    input  logic [arp_pkg::MAC_W-1:0]     i_src_mac,
    input  logic [arp_pkg::IP_W-1:0]      i_src_ip,
    input  logic [arp_pkg::IP_W-1:0]      i_dst_ip,
    input  logic [arp_pkg::IP_W-1:0]      i_query_ip,
    input  logic [arp_pkg::IP_W-1:0]      i_local_ip,
    input  logic [arp_pkg::TICK_W-1:0]    i_timer_period,
    input  logic                          i_q_full,
    output logic                          o_push,
    output arp_pkg::t_cmd                 o_cmd
);
    import arp_pkg::*;

    logic [TICK_W-1:0] r_tick;
    logic [TICK_W-1:0] n_tick;
    logic [TICK_W:0]   tick_sum;
    logic              age_now;
    logic              hdr_ok;
    logic              accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept;

    assign tick_sum = {1'b0, r_tick} + {{TICK_W{1'b0}}, 1'b1};

    always_comb begin
        n_tick  = r_tick;
        age_now = 1'b0;
        if (i_timer_period == '0) begin
            n_tick = '0;
        end else if (tick_sum >= {1'b0, i_timer_period}) begin
            n_tick  = '0;
            age_now = 1'b1;
        end else begin
            n_tick = tick_sum[TICK_W-1:0];
        end
    end

    assign hdr_ok = (i_hw_type == ARP_HW_ETHERNET) && (i_proto_type == ARP_PROTO_IPV4) &&
                    (i_hw_len == ARP_HW_LEN) && (i_proto_len == ARP_PROTO_LEN) &&
                    (i_dst_ip == i_local_ip);

    always_comb begin
        o_cmd.kind = K_NONE;
        o_cmd.ip   = i_src_ip;
        o_cmd.mac  = i_src_mac;
        case (i_func)
            FUNC_TICK: begin
                if (age_now) begin
                    o_cmd.kind = K_AGE;
                end
            end
            FUNC_ARP: begin
                if (hdr_ok && i_arp_op == ARP_OP_REQUEST) begin
                    o_cmd.kind = K_ARP_REQ;
                end else if (hdr_ok && i_arp_op == ARP_OP_REPLY) begin
                    o_cmd.kind = K_ARP_REP;
                end
            end
            FUNC_QUERY: begin
                o_cmd.kind = K_QUERY;
                o_cmd.ip   = i_query_ip;
            end
            default: begin
                o_cmd.kind = K_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
        end else if (accept && i_func == FUNC_TICK) begin
            r_tick <= n_tick;
        end
    end

endmodule

// ===== rtl/arp_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module arp_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  arp_pkg::t_cmd  i_data,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output arp_pkg::t_cmd  o_data
);
    import arp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `ASSERT_ALWAYS(a_count_bound, r_count <= FULL_CNT, "queue count over depth")
    `ASSERT_IMPLIES(a_empty_ptrs, r_count == '0, r_rd_ptr == r_wr_ptr,
        "empty queue with unequal pointers")

endmodule

// ===== rtl/arp_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module arp_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  arp_pkg::t_cmd              i_cmd,
    output logic                       o_pop,
    input  arp_pkg::t_age_cfg          i_age_cfg,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_action,
    output logic [arp_pkg::IP_W-1:0]   o_out_ip,
    output logic [arp_pkg::MAC_W-1:0]  o_out_mac,
    output logic [1:0]                 o_entry_status
);
    import arp_pkg::*;

    t_entry_state      r_state;
    t_entry_state      n_state;
    logic [IP_W-1:0]   r_ip;
    logic [IP_W-1:0]   n_ip;
    logic [MAC_W-1:0]  r_mac;
    logic [MAC_W-1:0]  n_mac;
    logic [TTL_W-1:0]  r_ttl;
    logic [TTL_W-1:0]  n_ttl;
    logic [RTR_W-1:0]  r_retries;
    logic [RTR_W-1:0]  n_retries;
    logic [TTL_W-1:0]  ttl_dec;
    logic              expire;

    logic              r_out_valid;
    t_action           r_action;
    t_action           n_action;
    logic [IP_W-1:0]   r_out_ip;
    logic [IP_W-1:0]   n_out_ip;
    logic [MAC_W-1:0]  r_out_mac;
    logic [MAC_W-1:0]  n_out_mac;

    assign o_pop   = i_q_valid && (!r_out_valid || i_out_ready);
    assign ttl_dec = r_ttl - TTL_W'(1);
    assign expire  = (ttl_dec == '0);

    always_comb begin
        n_state   = r_state;
        n_ip      = r_ip;
        n_mac     = r_mac;
        n_ttl     = r_ttl;
        n_retries = r_retries;
        case (i_cmd.kind)
            K_AGE: begin
                if (r_state == ST_OK) begin
                    n_ttl = ttl_dec;
                    if (expire) begin
                        n_state = ST_PENDING;
                        n_ttl   = i_age_cfg.pending_ttl;
                    end
                end else if (r_state == ST_PENDING) begin
                    n_ttl = ttl_dec;
                    if (expire && r_retries == '0) begin
                        n_state = ST_FREE;
                    end else if (expire) begin
                        n_retries = r_retries - RTR_W'(1);
                        n_ttl     = i_age_cfg.pending_ttl;
                    end
                end
            end
            K_ARP_REQ, K_ARP_REP: begin
                n_state   = ST_OK;
                n_ip      = i_cmd.ip;
                n_mac     = i_cmd.mac;
                n_ttl     = i_age_cfg.ok_ttl;
                n_retries = i_age_cfg.max_retries;
            end
            default: begin
                n_state = r_state;
            end
        endcase
    end

    always_comb begin
        n_action  = ACT_NONE;
        n_out_ip  = '0;
        n_out_mac = '0;
        case (i_cmd.kind)
            K_AGE: begin
                if (expire && (r_state == ST_OK ||
                    (r_state == ST_PENDING && r_retries != '0))) begin
                    n_action = ACT_REQUEST;
                    n_out_ip = r_ip;
                end
            end
            K_ARP_REQ: begin
                n_action  = ACT_REPLY;
                n_out_ip  = i_cmd.ip;
                n_out_mac = i_cmd.mac;
            end
            K_QUERY: begin
                n_out_ip = i_cmd.ip;
                if (r_state == ST_OK && r_ip == i_cmd.ip) begin
                    n_action  = ACT_HIT;
                    n_out_mac = r_mac;
                end else begin
                    n_action = ACT_REQUEST;
                end
            end
            default: begin
                n_action = ACT_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FREE;
            r_ip        <= '0;
            r_mac       <= '0;
            r_ttl       <= '0;
            r_retries   <= '0;
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_state     <= n_state;
            r_ip        <= n_ip;
            r_mac       <= n_mac;
            r_ttl       <= n_ttl;
            r_retries   <= n_retries;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_action  <= n_action;
            r_out_ip  <= n_out_ip;
            r_out_mac <= n_out_mac;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_action       = r_action;
    assign o_out_ip       = r_out_ip;
    assign o_out_mac      = r_out_mac;
    assign o_entry_status = r_state;

    `ASSERT_IMPLIES(a_hit_ok, r_out_valid && r_action == ACT_HIT, r_state == ST_OK,
        "resolve hit reported with entry not ok")
    `ASSERT_IMPLIES(a_reply_ok, r_out_valid && r_action == ACT_REPLY,
        r_state == ST_OK && r_ip == r_out_ip && r_mac == r_out_mac,
        "reply without matching refreshed entry")

endmodule

// ===== rtl/arp_single_entry_cache_top.sv =====
// Single-entry ARP cache with ageing and request retries.
// Path: an accepted item is written into the queue, then popped into the output register.
// Throughput: one item per cycle while the queue is not full; the classify queue decouples input from output stalls.
// Reset: synchronous, active low; control and config registers return to defaults, the entry goes free.
// The configuration port takes a write every cycle.
`timescale 1ns / 1ps
module arp_single_entry_cache_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [arp_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [31:0]                       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_func,
    input  logic [15:0]                       i_hw_type,
    input  logic [15:0]                       i_proto_type,
    input  logic [7:0]                        i_hw_len,
    input  logic [7:0]                        i_proto_len,
    input  logic [15:0]                       i_arp_op,
    input  logic [47:0]                       i_src_mac,
    input  logic [31:0]                       i_src_ip,
    input  logic [31:0]                       i_dst_ip,
    input  logic [31:0]                       i_query_ip,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_action,
    output logic [31:0]                       o_out_ip,
    output logic [47:0]                       o_out_mac,
    output logic [1:0]                        o_entry_status
);
    import arp_pkg::*;

    logic [IP_W-1:0]   r_local_ip;
    logic [TICK_W-1:0] r_timer_period;
    t_age_cfg          r_age_cfg;
    logic              cfg_wr;

    logic              q_full;
    logic              q_valid;
    logic              push;
    logic              pop;
    t_cmd              push_cmd;
    t_cmd              pop_cmd;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip            <= '0;
            r_age_cfg.ok_ttl      <= RST_OK_TTL;
            r_age_cfg.pending_ttl <= RST_PENDING_TTL;
            r_age_cfg.max_retries <= RST_MAX_RETRIES;
            r_timer_period        <= RST_TIMER_PERIOD;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_LOCAL_IP:     r_local_ip            <= i_cfg_data;
                CFG_OK_TTL:       r_age_cfg.ok_ttl      <= i_cfg_data[TTL_W-1:0];
                CFG_PENDING_TTL:  r_age_cfg.pending_ttl <= i_cfg_data[TTL_W-1:0];
                CFG_MAX_RETRIES:  r_age_cfg.max_retries <= i_cfg_data[RTR_W-1:0];
                CFG_TIMER_PERIOD: r_timer_period        <= i_cfg_data;
                default: begin
                    r_local_ip <= r_local_ip;
                end
            endcase
        end
    end

    arp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_hw_type      (i_hw_type),
        .i_proto_type   (i_proto_type),
        .i_hw_len       (i_hw_len),
        .i_proto_len    (i_proto_len),
        .i_arp_op       (i_arp_op),
        .i_src_mac      (i_src_mac),
        .i_src_ip       (i_src_ip),
        .i_dst_ip       (i_dst_ip),
        .i_query_ip     (i_query_ip),
        .i_local_ip     (r_local_ip),
        .i_timer_period (r_timer_period),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    arp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_data  (pop_cmd)
    );

    arp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_cmd          (pop_cmd),
        .o_pop          (pop),
        .i_age_cfg      (r_age_cfg),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_action       (o_action),
        .o_out_ip       (o_out_ip),
        .o_out_mac      (o_out_mac),
        .o_entry_status (o_entry_status)
    );

endmodule

// ===== verif/tb_arp_single_entry_cache_top.sv =====
`timescale 1ns / 1ps
module tb_arp_single_entry_cache_top;
    import arp_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 130;
    localparam int NUM_PHASES  = 6;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_len;
        logic [7:0]  proto_len;
        logic [15:0] arp_op;
        logic [47:0] src_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [31:0] query_ip;
    } t_arp_item;

    typedef struct packed {
        t_action      action;
        logic [31:0]  ip;
        logic [47:0]  mac;
        t_entry_state status;
    } t_cache_result;

    typedef struct {
        bit            is_reg;
        logic [2:0]    reg_idx;
        logic [31:0]   reg_data;
        t_arp_item     item;
        bit            has_want;
        t_cache_result want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_func;
    logic [15:0] i_hw_type;
    logic [15:0] i_proto_type;
    logic [7:0]  i_hw_len;
    logic [7:0]  i_proto_len;
    logic [15:0] i_arp_op;
    logic [47:0] i_src_mac;
    logic [31:0] i_src_ip;
    logic [31:0] i_dst_ip;
    logic [31:0] i_query_ip;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_action;
    logic [31:0] o_out_ip;
    logic [47:0] o_out_mac;
    logic [1:0]  o_entry_status;

    // typed-in expectation travels with the payload
    logic          drv_has_want;
    t_cache_result drv_want;

    // predictor copy of registers and entry
    logic [31:0]  cur_local_ip;
    logic [15:0]  cur_ok_ttl;
    logic [15:0]  cur_pending_ttl;
    logic [7:0]   cur_max_retries;
    logic [31:0]  cur_timer_period;
    t_entry_state ent_state;
    logic [31:0]  ent_ip;
    logic [47:0]  ent_mac;
    logic [15:0]  ent_ttl;
    logic [7:0]   ent_retries;
    logic [31:0]  tick_cnt;

    t_cache_result due_results[$];
    t_stim_row     dir_rows[$];
    logic [31:0]   ip_pool[4];

    int send_idle_pct = 27;
    int recv_idle_pct = 73;
    int n_err = 0;
    int n_items = 0;
    int n_checked = 0;
    int n_directed = 0;
    int act_seen[4] = '{0, 0, 0, 0};
    int cycle_cnt = 0;

    arp_single_entry_cache_top u_dut (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .o_in_ready,
        .i_func, .i_hw_type, .i_proto_type, .i_hw_len, .i_proto_len, .i_arp_op,
        .i_src_mac, .i_src_ip, .i_dst_ip, .i_query_ip,
        .o_out_valid, .i_out_ready,
        .o_action, .o_out_ip, .o_out_mac, .o_entry_status
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, due_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic t_cache_result mk_res(t_action a, logic [31:0] ip, logic [47:0] mac,
                                             t_entry_state s);
        t_cache_result r;
        r.action = a;
        r.ip     = ip;
        r.mac    = mac;
        r.status = s;
        return r;
    endfunction

    function automatic void apply_setting(logic [2:0] idx, logic [31:0] data);
        case (idx)
            CFG_LOCAL_IP:     cur_local_ip     = data;
            CFG_OK_TTL:       cur_ok_ttl       = data[15:0];
            CFG_PENDING_TTL:  cur_pending_ttl  = data[15:0];
            CFG_MAX_RETRIES:  cur_max_retries  = data[7:0];
            CFG_TIMER_PERIOD: cur_timer_period = data;
            default: ;
        endcase
    endfunction

    function automatic t_cache_result next_cache_result(t_arp_item it);
        t_cache_result res;
        logic          hdr_ok;
        res = mk_res(ACT_NONE, '0, '0, ST_FREE);
        case (it.func)
            FUNC_TICK: begin
                if (cur_timer_period == 0) begin
                    tick_cnt = '0;
                end else begin
                    tick_cnt = tick_cnt + 1;
                    if (tick_cnt >= cur_timer_period) begin
                        tick_cnt = '0;
                        if (ent_state != ST_FREE) begin
                            ent_ttl = ent_ttl - 16'd1;
                            if (ent_ttl == 0) begin
                                if (ent_state == ST_OK) begin
                                    ent_state  = ST_PENDING;
                                    ent_ttl    = cur_pending_ttl;
                                    res.action = ACT_REQUEST;
                                    res.ip     = ent_ip;
                                end else if (ent_retries == 0) begin
                                    ent_state = ST_FREE;
                                end else begin
                                    ent_retries = ent_retries - 8'd1;
                                    ent_ttl     = cur_pending_ttl;
                                    res.action  = ACT_REQUEST;
                                    res.ip      = ent_ip;
                                end
                            end
                        end
                    end
                end
            end
            FUNC_ARP: begin
                hdr_ok = it.hw_type == ARP_HW_ETHERNET && it.proto_type == ARP_PROTO_IPV4 &&
                         it.hw_len == ARP_HW_LEN && it.proto_len == ARP_PROTO_LEN &&
                         (it.arp_op == ARP_OP_REQUEST || it.arp_op == ARP_OP_REPLY) &&
                         it.dst_ip == cur_local_ip;
                if (hdr_ok) begin
                    if (it.arp_op == ARP_OP_REQUEST) begin
                        res.action = ACT_REPLY;
                        res.ip     = it.src_ip;
                        res.mac    = it.src_mac;
                    end
                    ent_ip      = it.src_ip;
                    ent_mac     = it.src_mac;
                    ent_state   = ST_OK;
                    ent_ttl     = cur_ok_ttl;
                    ent_retries = cur_max_retries;
                end
            end
            FUNC_QUERY: begin
                res.ip = it.query_ip;
                if (ent_state == ST_OK && ent_ip == it.query_ip) begin
                    res.action = ACT_HIT;
                    res.mac    = ent_mac;
                end else begin
                    res.action = ACT_REQUEST;
                end
            end
            default: ;
        endcase
        res.status = ent_state;
        return res;
    endfunction

    function automatic void note_mismatch(string what, logic [47:0] want, logic [47:0] got);
        n_err++;
        if (n_err <= 10)
            $display("mismatch in %s at cycle %0d: expected %0h, got %0h",
                     what, cycle_cnt, want, got);
    endfunction

    always @(posedge i_clk) begin
        t_cache_result want;
        t_arp_item     seen;
        if (i_rst_n === 1'b1) begin
            if (o_out_valid && i_out_ready) begin
                n_checked++;
                act_seen[o_action]++;
                if (due_results.size() == 0) begin
                    note_mismatch("unexpected transfer, ip", '0, o_out_ip);
                end else begin
                    want = due_results.pop_front();
                    if (o_action !== want.action)
                        note_mismatch("action", want.action, o_action);
                    if (o_out_ip !== want.ip)
                        note_mismatch("out_ip", want.ip, o_out_ip);
                    if (o_out_mac !== want.mac)
                        note_mismatch("out_mac", want.mac, o_out_mac);
                    if (o_entry_status !== want.status)
                        note_mismatch("entry_status", want.status, o_entry_status);
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                apply_setting(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) begin
                n_items++;
                seen = {i_func, i_hw_type, i_proto_type, i_hw_len, i_proto_len, i_arp_op,
                        i_src_mac, i_src_ip, i_dst_ip, i_query_ip};
                want = next_cache_result(seen);
                due_results.push_back(drv_has_want ? drv_want : want);
            end
        end
    end

    function automatic t_arp_item tick_item();
        t_arp_item it;
        it = '1;
        it.func = FUNC_TICK;
        return it;
    endfunction

    function automatic t_arp_item query_item(logic [31:0] ip);
        t_arp_item it;
        it = '0;
        it.func     = FUNC_QUERY;
        it.query_ip = ip;
        return it;
    endfunction

    function automatic t_arp_item arp_item(logic [15:0] op, logic [47:0] mac,
                                           logic [31:0] sip, logic [31:0] tip);
        t_arp_item it;
        it = '0;
        it.func       = FUNC_ARP;
        it.hw_type    = ARP_HW_ETHERNET;
        it.proto_type = ARP_PROTO_IPV4;
        it.hw_len     = ARP_HW_LEN;
        it.proto_len  = ARP_PROTO_LEN;
        it.arp_op     = op;
        it.src_mac    = mac;
        it.src_ip     = sip;
        it.dst_ip     = tip;
        it.query_ip   = '1;
        return it;
    endfunction

    function automatic void add_item(t_arp_item it);
        t_stim_row r;
        r.is_reg   = 1'b0;
        r.reg_idx  = '0;
        r.reg_data = '0;
        r.item     = it;
        r.has_want = 1'b0;
        r.want     = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_checked(t_arp_item it, t_cache_result want);
        add_item(it);
        dir_rows[$].has_want = 1'b1;
        dir_rows[$].want     = want;
    endfunction

    function automatic void add_reg(logic [2:0] idx, logic [31:0] data);
        add_item('0);
        dir_rows[$].is_reg   = 1'b1;
        dir_rows[$].reg_idx  = idx;
        dir_rows[$].reg_data = data;
    endfunction

    function automatic t_arp_item random_item(output bit ignored);
        t_arp_item it;
        int        pick;
        it.func       = FUNC_TICK;
        it.hw_type    = 16'($urandom);
        it.proto_type = 16'($urandom);
        it.hw_len     = 8'($urandom);
        it.proto_len  = 8'($urandom);
        it.arp_op     = 16'($urandom);
        it.src_mac    = {16'($urandom), $urandom};
        it.src_ip     = $urandom;
        it.dst_ip     = $urandom;
        it.query_ip   = $urandom;
        ignored = 1'b0;
        pick = $urandom_range(99);
        if (pick < 40) begin
            it.func = FUNC_TICK;
        end else if (pick < 75) begin
            it = arp_item($urandom_range(1) ? ARP_OP_REQUEST : ARP_OP_REPLY, it.src_mac,
                          $urandom_range(3) == 0 ? it.src_ip : ip_pool[$urandom_range(3)],
                          $urandom_range(9) == 0 ? it.dst_ip : cur_local_ip);
            it.query_ip = $urandom;
            if (pick >= 65) begin
                ignored = 1'b1;
                case ($urandom_range(5))
                    0: it.hw_type    = it.hw_type ^ 16'($urandom_range(1, 65535));
                    1: it.proto_type = it.proto_type ^ 16'($urandom_range(1, 65535));
                    2: it.hw_len     = it.hw_len ^ 8'($urandom_range(1, 255));
                    3: it.proto_len  = it.proto_len ^ 8'($urandom_range(1, 255));
                    4: it.arp_op     = $urandom_range(1) ? 16'd0 : 16'($urandom_range(3, 65535));
                    default: it.dst_ip = it.dst_ip ^ $urandom_range(1, 32'hFFFF_FFFF);
                endcase
            end
        end else if (pick < 95) begin
            it.func = FUNC_QUERY;
            case ($urandom_range(4))
                0, 1, 2: it.query_ip = ent_ip;
                3: it.query_ip = ip_pool[$urandom_range(3)];
                default: ;
            endcase
        end else begin
            it.func = FUNC_UNUSED;
            ignored = 1'b1;
        end
        return it;
    endfunction

    // hold off new items until every outstanding result has been transferred
    task automatic settle_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_setting(logic [2:0] idx, logic [31:0] data);
        settle_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_item(t_arp_item it, bit has_want, t_cache_result want);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_func       <= it.func;
        i_hw_type    <= it.hw_type;
        i_proto_type <= it.proto_type;
        i_hw_len     <= it.hw_len;
        i_proto_len  <= it.proto_len;
        i_arp_op     <= it.arp_op;
        i_src_mac    <= it.src_mac;
        i_src_ip     <= it.src_ip;
        i_dst_ip     <= it.dst_ip;
        i_query_ip   <= it.query_ip;
        drv_has_want <= has_want;
        drv_want     <= want;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
    endtask

    initial begin
        t_arp_item   it;
        bit          ignored;
        int          n_counted;
        logic [31:0] s_ip;
        logic [15:0] s_ok;
        logic [15:0] s_pend;
        logic [7:0]  s_retry;
        logic [31:0] s_period;

        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_out_ready  = 1'b0;
        {i_func, i_hw_type, i_proto_type, i_hw_len, i_proto_len, i_arp_op} = '0;
        {i_src_mac, i_src_ip, i_dst_ip, i_query_ip} = '0;
        drv_has_want = 1'b0;
        drv_want     = '0;

        cur_local_ip     = '0;
        cur_ok_ttl       = RST_OK_TTL;
        cur_pending_ttl  = RST_PENDING_TTL;
        cur_max_retries  = RST_MAX_RETRIES;
        cur_timer_period = RST_TIMER_PERIOD;
        ent_state        = ST_FREE;
        ent_ip           = '0;
        ent_mac          = '0;
        ent_ttl          = '0;
        ent_retries      = '0;
        tick_cnt         = '0;

        add_checked(tick_item(), mk_res(ACT_NONE, '0, '0, ST_FREE));
        add_checked(query_item('0), mk_res(ACT_REQUEST, '0, '0, ST_FREE));
        add_checked('1, mk_res(ACT_NONE, '0, '0, ST_FREE));
        add_checked(arp_item(ARP_OP_REQUEST, '1, '1, '0), mk_res(ACT_REPLY, '1, '1, ST_OK));
        add_checked(query_item('1), mk_res(ACT_HIT, '1, '1, ST_OK));
        it = arp_item(ARP_OP_REQUEST, '0, '0, '0);
        it.hw_type = 16'hFFFF;
        add_checked(it, mk_res(ACT_NONE, '0, '0, ST_OK));
        it = arp_item(ARP_OP_REQUEST, '0, '0, '0);
        it.proto_type = 16'h0000;
        add_checked(it, mk_res(ACT_NONE, '0, '0, ST_OK));
        it = arp_item(ARP_OP_REQUEST, '0, '0, '0);
        it.hw_len = 8'h00;
        add_checked(it, mk_res(ACT_NONE, '0, '0, ST_OK));
        it = arp_item(ARP_OP_REQUEST, '0, '0, '0);
        it.proto_len = 8'hFF;
        add_checked(it, mk_res(ACT_NONE, '0, '0, ST_OK));
        add_checked(arp_item(16'hFFFF, '0, '0, '0), mk_res(ACT_NONE, '0, '0, ST_OK));
        add_checked(arp_item(16'd0, '0, '0, '0), mk_res(ACT_NONE, '0, '0, ST_OK));
        add_checked(arp_item(ARP_OP_REQUEST, '0, '0, 32'd1), mk_res(ACT_NONE, '0, '0, ST_OK));
        add_item(arp_item(ARP_OP_REPLY, '0, '0, '0));
        repeat (9) add_item(tick_item());
        add_reg(CFG_TIMER_PERIOD, 32'd0);
        add_item(arp_item(ARP_OP_REPLY, 48'h0123_4567_89AB, 32'hC0A8_0001, '0));
        add_item(tick_item());
        add_reg(CFG_OK_TTL, 32'd0);
        add_reg(CFG_TIMER_PERIOD, 32'd1);
        add_item(arp_item(ARP_OP_REPLY, 48'hFEDC_BA98_7654, 32'h0A00_0002, '0));
        add_item(tick_item());

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_reg) begin
                write_setting(dir_rows[k].reg_idx, dir_rows[k].reg_data);
            end else begin
                send_item(dir_rows[k].item, dir_rows[k].has_want, dir_rows[k].want);
                n_directed++;
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == 2) begin
                send_idle_pct = 73;
                recv_idle_pct = 27;
            end else if (phase == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            s_ip     = $urandom;
            s_ok     = 16'($urandom_range(1, 6));
            s_pend   = 16'($urandom_range(1, 3));
            s_retry  = 8'($urandom_range(0, 4));
            s_period = $urandom_range(1, 3);
            case (phase)
                1: begin
                    s_ip     = '0;
                    s_ok     = '1;
                    s_pend   = '1;
                    s_retry  = '1;
                    s_period = '1;
                end
                2: begin
                    s_ip     = '1;
                    s_ok     = 16'd1;
                    s_pend   = 16'd1;
                    s_retry  = 8'd0;
                    s_period = 32'd1;
                end
                default: ;
            endcase
            write_setting(CFG_LOCAL_IP, s_ip);
            write_setting(CFG_OK_TTL, {16'd0, s_ok});
            write_setting(CFG_PENDING_TTL, {16'd0, s_pend});
            write_setting(CFG_MAX_RETRIES, {24'd0, s_retry});
            write_setting(CFG_TIMER_PERIOD, s_period);
            foreach (ip_pool[j]) ip_pool[j] = $urandom;

            n_counted = 0;
            while (n_counted < PHASE_ITEMS) begin
                it = random_item(ignored);
                send_item(it, 1'b0, '0);
                if (!ignored) n_counted++;
                if ($urandom_range(63) == 0) settle_results();
            end
        end

        settle_results();
        repeat (8) @(posedge i_clk);

        $display("%0d items (%0d directed) across %0d register settings, extremes included",
                 n_items, n_directed, NUM_PHASES + 3);
        $display("%0d results: %0d replies, %0d requests, %0d hits, %0d without action",
                 n_checked, act_seen[ACT_REPLY], act_seen[ACT_REQUEST], act_seen[ACT_HIT],
                 act_seen[ACT_NONE]);
        if (n_err == 0 && due_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d results missing", n_err, due_results.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
